FILE: src/urgd_pkg.sv
package urgd_pkg;

  // Horizon limit and derived counter widths
  localparam int MAX_STEPS = 255;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int CNT_W     = (STEP_W > 8) ? STEP_W : 8;

  // Rollout heading accumulator modulus (1/655360 turn)
  localparam int ROLL_TURN = 655360;

  // CORDIC: two iterations per clock
  localparam int CORDIC_ITERS = 24;
  localparam int CORD_PAIRS   = CORDIC_ITERS / 2;
  localparam int PAIR_W       = $clog2(CORD_PAIRS);
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Square root: one result bit per clock
  localparam int SQRT_ITERS = 32;
  localparam int ITER_W     = 5;

  // Reciprocals of 5 for the divide-by-ten steps
  localparam logic [20:0] RECIP5_ANG  = 21'd1677722;   // ceil(2^23 / 5)
  localparam logic [24:0] RECIP5_STEP = 25'd26843546;  // ceil(2^27 / 5)

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y   = 3'd4;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE, S_ANG_MUL, S_ANG_SET, S_CORD, S_STEP_MUL, S_STEP_DIV, S_STEP_ACC,
    S_HEAD, S_HCORD, S_ROT_A, S_ROT_B, S_ROT_C, S_SQ_A, S_SQ_B, S_SQ_C,
    S_SQRT, S_DONE
  } state_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ANG_MUL, OP_ANG_SET, OP_CORD, OP_STEP_MUL, OP_STEP_DIV,
    OP_STEP_ACC, OP_HEAD, OP_ROT_A, OP_ROT_B, OP_ROT_C, OP_SQ_A, OP_SQ_B,
    OP_SQ_C, OP_SQRT, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [PAIR_W-1:0] pair;
  } dp_cmd_t;

  typedef struct packed {
    logic steps_zero;
  } dp_stat_t;

  // CORDIC arctangent table, 2^32 per turn
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // round(65536*r / 10) for the remainder r of acc / 5
  function automatic logic [14:0] ang_frac(input logic [2:0] r);
    logic [14:0] f;
    case (r)
      3'd1: f = 15'd6554;
      3'd2: f = 15'd13107;
      3'd3: f = 15'd19661;
      3'd4: f = 15'd26214;
      default: f = 15'd0;
    endcase
    return f;
  endfunction

endpackage

FILE: src/urgd_ctrl.sv
module urgd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output urgd_pkg::dp_cmd_t  cmd,
  input  urgd_pkg::dp_stat_t stat
);
  import urgd_pkg::*;

  state_t state, state_next;
  logic [ITER_W-1:0] cnt, cnt_next;
  logic loop_last;

  // End of the current iteration loop
  assign loop_last = (state == S_SQRT) ? (cnt == ITER_W'(SQRT_ITERS - 1))
                                       : (cnt == ITER_W'(CORD_PAIRS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Iteration counter
  always_comb begin
    if ((state == S_CORD || state == S_HCORD || state == S_SQRT) && !loop_last)
      cnt_next = cnt + 1'b1;
    else
      cnt_next = '0;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (start) state_next = S_ANG_MUL;
      S_ANG_MUL:  state_next = stat.steps_zero ? S_HEAD : S_ANG_SET;
      S_ANG_SET:  state_next = S_CORD;
      S_CORD:     if (loop_last) state_next = S_STEP_MUL;
      S_STEP_MUL: state_next = S_STEP_DIV;
      S_STEP_DIV: state_next = S_STEP_ACC;
      S_STEP_ACC: state_next = S_ANG_MUL;
      S_HEAD:     state_next = S_HCORD;
      S_HCORD:    if (loop_last) state_next = S_ROT_A;
      S_ROT_A:    state_next = S_ROT_B;
      S_ROT_B:    state_next = S_ROT_C;
      S_ROT_C:    state_next = S_SQ_A;
      S_SQ_A:     state_next = S_SQ_B;
      S_SQ_B:     state_next = S_SQ_C;
      S_SQ_C:     state_next = S_SQRT;
      S_SQRT:     if (loop_last) state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    busy     = (state != S_IDLE);
    cmd.pair = cnt[PAIR_W-1:0];
    unique case (state)
      S_IDLE:     cmd.op = start ? OP_LOAD : OP_NONE;
      S_ANG_MUL:  cmd.op = OP_ANG_MUL;
      S_ANG_SET:  cmd.op = OP_ANG_SET;
      S_CORD:     cmd.op = OP_CORD;
      S_STEP_MUL: cmd.op = OP_STEP_MUL;
      S_STEP_DIV: cmd.op = OP_STEP_DIV;
      S_STEP_ACC: cmd.op = OP_STEP_ACC;
      S_HEAD:     cmd.op = OP_HEAD;
      S_HCORD:    cmd.op = OP_CORD;
      S_ROT_A:    cmd.op = OP_ROT_A;
      S_ROT_B:    cmd.op = OP_ROT_B;
      S_ROT_C:    cmd.op = OP_ROT_C;
      S_SQ_A:     cmd.op = OP_SQ_A;
      S_SQ_B:     cmd.op = OP_SQ_B;
      S_SQ_C:     cmd.op = OP_SQ_C;
      S_SQRT:     cmd.op = OP_SQRT;
      S_DONE:     cmd.op = OP_FINISH;
      default:    cmd.op = OP_NONE;
    endcase
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> (state == S_IDLE))
    else $error("controller not idle after reset");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_ANG_MUL))
    else $error("accepted transaction did not start rollout");
  a_cord_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORD || state == S_HCORD) |-> (cnt < ITER_W'(CORD_PAIRS)))
    else $error("CORDIC counter out of range");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> (state == S_IDLE))
    else $error("controller did not return to idle after finish");

endmodule

FILE: src/urgd_datapath.sv
module urgd_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  urgd_pkg::dp_cmd_t              cmd,
  output urgd_pkg::dp_stat_t             stat,
  input  logic                           cfg_write,
  input  logic [urgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic signed [23:0]             speed,
  input  logic signed [20:0]             turn_rate,
  input  logic [7:0]                     step_count,
  output logic                           done,
  output logic [31:0]                    goal_distance
);
  import urgd_pkg::*;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [31:0] z;
  } cord_t;

  // One CORDIC rotation-mode iteration
  function automatic cord_t cord_step(input cord_t a, input logic [4:0] i);
    cord_t b;
    logic signed [33:0] dx, dy;
    dx = a.y >>> i;
    dy = a.x >>> i;
    if (!a.z[31]) begin
      b.x = a.x - dx;
      b.y = a.y + dy;
      b.z = a.z - $signed(atan_lut(i));
    end else begin
      b.x = a.x + dx;
      b.y = a.y - dy;
      b.z = a.z + $signed(atan_lut(i));
    end
    return b;
  endfunction

  // round(p / (10 * 2^30)), ties away from zero
  function automatic logic signed [23:0] step_round(input logic signed [57:0] p);
    logic [57:0] m;
    logic [57:0] t;
    logic [23:0] n;
    logic [48:0] q;
    m = p[57] ? 58'(-p) : 58'(p);
    t = (m + (58'd5 << 30)) >> 31;
    n = t[23:0];
    q = 49'(n) * 49'(RECIP5_STEP);
    return p[57] ? -$signed({2'b00, q[48:27]}) : $signed({2'b00, q[48:27]});
  endfunction

  // round(s / 2^30), ties away from zero
  function automatic logic signed [33:0] rnd30(input logic signed [66:0] s);
    logic [66:0] m;
    logic [66:0] t;
    m = s[66] ? 67'(-s) : 67'(s);
    t = (m + (67'd1 << 29)) >> 30;
    return s[66] ? -$signed(t[33:0]) : $signed(t[33:0]);
  endfunction

  // Configuration registers
  logic signed [31:0] origin_x, origin_y, goal_x, goal_y;
  logic [15:0] heading;

  // Rollout state
  logic signed [23:0] speed_q;
  logic signed [20:0] rate_q;
  logic [STEP_W-1:0] steps_left;
  logic [19:0] acc;
  logic [16:0] acc_div5;
  logic signed [33:0] cx, cy;
  logic signed [31:0] cz;
  logic [1:0] quad;
  logic signed [57:0] prod_c, prod_s;
  logic signed [23:0] mv_x, mv_y;
  logic signed [31:0] lx, ly;

  // Rotation and distance
  logic signed [65:0] rp1, rp2;
  logic signed [33:0] wx, wy;
  logic [34:0] ax, ay;
  logic sat;
  logic [63:0] sq, rem, root, bitm;

  // Combinational helpers
  logic signed [33:0] cos_v, sin_v, ma, mb;
  cord_t cord_in, cord_mid, cord_out;
  logic [4:0] it0, it1;
  logic [40:0] ang_prod;
  logic [19:0] five_a;
  logic [2:0] rem5;
  logic [31:0] step_ang, head_ang;
  logic signed [21:0] asum;
  logic signed [34:0] dx, dy;
  logic [64:0] sum65, trial, rnd;
  logic [CNT_W-1:0] n_ext;

  assign stat.steps_zero = (steps_left == '0);

  // Quadrant fold of the CORDIC result
  always_comb begin
    case (quad)
      2'd0: begin cos_v = cx;  sin_v = cy;  end
      2'd1: begin cos_v = -cy; sin_v = cx;  end
      2'd2: begin cos_v = -cx; sin_v = -cy; end
      default: begin cos_v = cy; sin_v = -cx; end
    endcase
  end

  // Two CORDIC iterations per clock
  assign it0 = {cmd.pair, 1'b0};
  assign it1 = {cmd.pair, 1'b1};
  assign cord_in  = '{x: cx, y: cy, z: cz};
  assign cord_mid = cord_step(cord_in, it0);
  assign cord_out = cord_step(cord_mid, it1);

  // Heading accumulator to binary angle: acc = 5a + r
  assign ang_prod = 41'(acc) * 41'(RECIP5_ANG);
  assign five_a   = 20'({acc_div5, 2'b00}) + 20'(acc_div5);
  assign rem5     = 3'(acc - five_a);
  assign step_ang = {acc_div5, 15'd0} + 32'(ang_frac(rem5));
  assign head_ang = {heading, 16'd0};

  assign asum  = $signed({2'b00, acc}) + 22'(rate_q);
  assign ma    = (cmd.op == OP_ROT_A) ? cos_v : sin_v;
  assign mb    = (cmd.op == OP_ROT_A) ? sin_v : cos_v;
  assign dx    = 35'(wx) - 35'(goal_x);
  assign dy    = 35'(wy) - 35'(goal_y);
  assign sum65 = {1'b0, sq} + {1'b0, 64'(ay[31:0]) * 64'(ay[31:0])};
  assign trial = {1'b0, root} + {1'b0, bitm};
  assign rnd   = (rem > root) ? ({1'b0, root} + 65'd1) : {1'b0, root};
  assign n_ext = CNT_W'(step_count);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      heading  <= '0;
      goal_x   <= '0;
      goal_y   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_HEADING:  heading  <= cfg_data[15:0];
        REG_GOAL_X:   goal_x   <= cfg_data;
        REG_GOAL_Y:   goal_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (cmd.op == OP_FINISH);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          speed_q    <= speed;
          rate_q     <= turn_rate;
          steps_left <= (n_ext > CNT_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : STEP_W'(n_ext);
          acc        <= '0;
          lx         <= '0;
          ly         <= '0;
        end
        OP_ANG_MUL: acc_div5 <= ang_prod[39:23];
        OP_ANG_SET: begin
          cx   <= CORDIC_GAIN;
          cy   <= '0;
          cz   <= $signed({2'b00, step_ang[29:0]});
          quad <= step_ang[31:30];
        end
        OP_HEAD: begin
          cx   <= CORDIC_GAIN;
          cy   <= '0;
          cz   <= $signed({2'b00, head_ang[29:0]});
          quad <= head_ang[31:30];
        end
        OP_CORD: begin
          cx <= cord_out.x;
          cy <= cord_out.y;
          cz <= cord_out.z;
        end
        OP_STEP_MUL: begin
          prod_c <= 58'(speed_q) * 58'(cos_v);
          prod_s <= 58'(speed_q) * 58'(sin_v);
        end
        OP_STEP_DIV: begin
          mv_x <= step_round(prod_c);
          mv_y <= step_round(prod_s);
        end
        OP_STEP_ACC: begin
          lx <= lx + 32'(mv_x);
          ly <= ly + 32'(mv_y);
          steps_left <= steps_left - 1'b1;
          if (asum < 0)
            acc <= 20'(asum + 22'sd655360);
          else if (asum >= 22'sd655360)
            acc <= 20'(asum - 22'sd655360);
          else
            acc <= 20'(asum);
        end
        OP_ROT_A: begin
          rp1 <= 66'(lx) * 66'(ma);
          rp2 <= 66'(ly) * 66'(mb);
        end
        OP_ROT_B: begin
          wx  <= 34'(origin_x) + rnd30(67'(rp1) - 67'(rp2));
          rp1 <= 66'(lx) * 66'(ma);
          rp2 <= 66'(ly) * 66'(mb);
        end
        OP_ROT_C: wy <= 34'(origin_y) + rnd30(67'(rp1) + 67'(rp2));
        OP_SQ_A: begin
          ax  <= dx[34] ? 35'(-dx) : 35'(dx);
          ay  <= dy[34] ? 35'(-dy) : 35'(dy);
          sat <= 1'b0;
        end
        OP_SQ_B: begin
          sq  <= ax[31:0] * ax[31:0];
          sat <= (ax[34:32] != '0) || (ay[34:32] != '0);
        end
        OP_SQ_C: begin
          sat  <= sat | sum65[64];
          rem  <= sum65[63:0];
          root <= '0;
          bitm <= 64'd1 << 62;
        end
        OP_SQRT: begin
          if ({1'b0, rem} >= trial) begin
            rem  <= rem - trial[63:0];
            root <= (root >> 1) + bitm;
          end else begin
            root <= root >> 1;
          end
          bitm <= bitm >> 2;
        end
        OP_FINISH: begin
          if (sat || (rnd[64:32] != '0))
            goal_distance <= '1;
          else
            goal_distance <= rnd[31:0];
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/unicycle_rollout_goal_distance.sv
// Unicycle rollout scorer for a dynamic-window local planner.
// Input channel: speed, turn_rate and step_count are taken at a rising edge
// where start is high and busy is low; the block then runs the rollout and
// holds busy high until the result is out.
// Output channel: goal_distance is valid for exactly one cycle while done is
// high. The receiver cannot stall the block; it must take the transaction
// in that cycle.
// Configuration: cfg_write with cfg_index 0..4 writes origin_x, origin_y,
// heading, goal_x, goal_y from cfg_data; other indexes are ignored. Write
// only while busy is low.
// Sequence: each of the n integration steps, n being step_count clamped to
// MAX_STEPS, runs the shared CORDIC (two iterations per cycle) between an
// angle multiply and set and a speed multiply, divide and accumulate; the tail
// is the heading CORDIC, the rotation and squares, and a bit-serial square root.
// One transaction is in flight at a time; a new one can be accepted in the
// cycle done is high.
// Reset: synchronous, active high; clears the controller and sets all
// configuration registers to zero.
module unicycle_rollout_goal_distance (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [23:0]             speed,
  input  logic signed [20:0]             turn_rate,
  input  logic [7:0]                     step_count,
  output logic                           done,
  output logic [31:0]                    goal_distance,
  input  logic                           cfg_write,
  input  logic [urgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import urgd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  urgd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  urgd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .speed         (speed),
    .turn_rate     (turn_rate),
    .step_count    (step_count),
    .done          (done),
    .goal_distance (goal_distance)
  );

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a transaction is still running");

endmodule
